// ===== hw/rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipv4nat_pkg.sv =====
`default_nettype none

package ipv4nat_pkg;

    // Protocol numbers with a known L4 checksum position
    localparam logic [7:0] PROTO_TCP     = 8'd6;
    localparam logic [7:0] PROTO_UDP     = 8'd17;
    localparam logic [7:0] PROTO_DCCP    = 8'd33;
    localparam logic [7:0] PROTO_UDPLITE = 8'd136;

    // Checksum byte position inside the L4 header
    localparam logic [15:0] TCP_CSUM_POS   = 16'd16;
    localparam logic [15:0] SHORT_CSUM_POS = 16'd6;

    localparam logic [15:0] CSUM_ALL_ONES = 16'hFFFF;

    // Widths of the intermediate sums
    localparam int DELTA_W = 19;  // four 17-bit half sums
    localparam int SUM_W   = 20;  // checksum word plus delta
    localparam int FOLD_W  = 17;  // after the first carry fold
    localparam int OFF_W   = 7;   // 60-byte header plus 16, at most

    localparam int IN_TDATA_W  = 208;
    localparam int OUT_TDATA_W = 112;

    // Input word, last field in the lowest bits
    typedef struct packed {
        logic [15:0] l4_checksum;
        logic [15:0] packet_length;
        logic [12:0] fragment_units;
        logic [7:0]  protocol;
        logic [3:0]  header_words;
        logic [15:0] ip_checksum;
        logic [31:0] new_dst;
        logic [31:0] new_src;
        logic [31:0] old_dst;
        logic [31:0] old_src;
    } in_item_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [31:0] dst_out;
        logic [31:0] src_out;
        logic [15:0] l4_offset;
        logic [15:0] l4_checksum_out;
        logic [15:0] ip_checksum_out;
    } out_item_t;

    // After stage 1: address delta and L4 eligibility
    typedef struct packed {
        logic [DELTA_W-1:0] delta;
        logic [15:0]        ip_csum;
        logic [15:0]        l4_csum;
        logic               tcp_like;
        logic               l4_ok;
        logic [OFF_W-1:0]   l4_off;
        logic [31:0]        src;
        logic [31:0]        dst;
    } s1_item_t;

    // After stage 2: sums folded once
    typedef struct packed {
        logic [FOLD_W-1:0] ip_fold;
        logic [FOLD_W-1:0] l4_fold;
        logic              tcp_like;
        logic              l4_ok;
        logic              l4_nonzero;
        logic [OFF_W-1:0]  l4_off;
        logic [31:0]       src;
        logic [31:0]       dst;
    } s2_item_t;

    // Sum of the two 16-bit halves of a 32-bit word
    function automatic logic [16:0] halves_sum(input logic [31:0] v);
        return {1'b0, v[15:0]} + {1'b0, v[31:16]};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ipv4nat_prep.sv =====
`default_nettype none

module ipv4nat_prep (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic                  in_op,
    input  wire ipv4nat_pkg::in_item_t in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ipv4nat_pkg::s1_item_t      out_item
);
    import ipv4nat_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    s1_item_t    item_reg;
    s1_item_t    item_next;

    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] hdr_bytes;
    logic [15:0] frag_bytes;
    logic [15:0] pos;
    logic [15:0] off_full;
    logic        tcp_like;
    logic        udp_like;

    // Pick the replacement addresses and classify the L4 header
    always_comb begin
        src        = in_op ? 32'd0 : in_item.new_src;
        dst        = in_op ? 32'd0 : in_item.new_dst;
        hdr_bytes  = {10'd0, in_item.header_words, 2'b00};
        frag_bytes = {in_item.fragment_units, 3'b000};
        tcp_like   = (in_item.protocol == PROTO_TCP) || (in_item.protocol == PROTO_DCCP);
        udp_like   = (in_item.protocol == PROTO_UDP) || (in_item.protocol == PROTO_UDPLITE);
        pos        = (in_item.protocol == PROTO_TCP) ? TCP_CSUM_POS : SHORT_CSUM_POS;
        off_full   = hdr_bytes + pos - frag_bytes;

        item_next.delta    = {2'b00, halves_sum(in_item.old_src)}
                           + {2'b00, halves_sum(in_item.old_dst)}
                           + {2'b00, halves_sum(~src)}
                           + {2'b00, halves_sum(~dst)};
        item_next.ip_csum  = in_item.ip_checksum;
        item_next.l4_csum  = in_item.l4_checksum;
        item_next.tcp_like = tcp_like;
        item_next.l4_ok    = (hdr_bytes <= in_item.packet_length)
                           && (tcp_like || udp_like) && (frag_bytes <= pos);
        item_next.l4_off   = off_full[OFF_W-1:0];
        item_next.src      = src;
        item_next.dst      = dst;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Advance the stage when it is empty or downstream has room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4nat_sum.sv =====
`default_nettype none

module ipv4nat_sum (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ipv4nat_pkg::s1_item_t in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ipv4nat_pkg::s2_item_t      out_item
);
    import ipv4nat_pkg::*;

    logic            valid_reg;
    logic            valid_next;
    s2_item_t        item_reg;
    s2_item_t        item_next;
    logic [SUM_W-1:0] ip_sum;
    logic [SUM_W-1:0] l4_sum;

    // Add the delta to both checksum words and fold the carries once
    always_comb begin
        ip_sum = {{(SUM_W-16){1'b0}}, in_item.ip_csum}
               + {{(SUM_W-DELTA_W){1'b0}}, in_item.delta};
        l4_sum = {{(SUM_W-16){1'b0}}, in_item.l4_csum}
               + {{(SUM_W-DELTA_W){1'b0}}, in_item.delta};

        item_next.ip_fold    = {1'b0, ip_sum[15:0]}
                             + {{(FOLD_W-(SUM_W-16)){1'b0}}, ip_sum[SUM_W-1:16]};
        item_next.l4_fold    = {1'b0, l4_sum[15:0]}
                             + {{(FOLD_W-(SUM_W-16)){1'b0}}, l4_sum[SUM_W-1:16]};
        item_next.tcp_like   = in_item.tcp_like;
        item_next.l4_ok      = in_item.l4_ok;
        item_next.l4_nonzero = (in_item.l4_csum != 16'd0);
        item_next.l4_off     = in_item.l4_off;
        item_next.src        = in_item.src;
        item_next.dst        = in_item.dst;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Advance the stage when it is empty or downstream has room
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4nat_final.sv =====
`default_nettype none

module ipv4nat_final (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ipv4nat_pkg::s2_item_t in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ipv4nat_pkg::out_item_t     out_item,
    output logic                       out_l4_write
);
    import ipv4nat_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    out_item_t   item_reg;
    out_item_t   item_next;
    logic        write_reg;
    logic        write_next;
    logic [15:0] l4_word;

    // Second carry fold, all-ones fixup for TCP and DCCP, write decision
    always_comb begin
        l4_word    = in_item.l4_fold[15:0] + {15'd0, in_item.l4_fold[16]};
        write_next = in_item.l4_ok && (in_item.tcp_like || in_item.l4_nonzero);

        item_next.ip_checksum_out = in_item.ip_fold[15:0] + {15'd0, in_item.ip_fold[16]};
        if (!write_next) begin
            item_next.l4_checksum_out = 16'd0;
        end else if (in_item.tcp_like && (l4_word == CSUM_ALL_ONES)) begin
            item_next.l4_checksum_out = 16'd0;
        end else begin
            item_next.l4_checksum_out = l4_word;
        end
        item_next.l4_offset = write_next ? {{(16-OFF_W){1'b0}}, in_item.l4_off} : 16'd0;
        item_next.src_out   = in_item.src;
        item_next.dst_out   = in_item.dst;
    end

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    // Output register: hold the word until the receiver takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg  <= item_next;
            write_reg <= write_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_item     = item_reg;
    assign out_l4_write = write_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4_nat_checksum_rewrite.sv =====
// IPv4 address rewrite with incremental header and L4 checksum patch.
// Input stream s_axis: one parsed IPv4 header per word. s_axis_tuser
// carries op (0 = write new addresses, 1 = clear both addresses); s_axis_tdata
// carries the old and new addresses, the IP checksum, IHL, protocol,
// fragment offset, buffered packet length and the fetched L4 checksum word.
// Output stream m_axis: one result word per input word, in order.
// m_axis_tuser carries l4_write; when it is low the L4 checksum and
// offset fields read as zero and the L4 word must be left alone.
// Three register stages lie between acceptance and m_axis_tvalid: delta and
// classification, add and first carry fold, second fold and output register.
// Throughput is one word per cycle when the receiver does not stall; each
// stage holds a valid bit and takes a new word whenever it is empty or its
// successor takes its word. When the receiver stalls, the output register
// holds its word and the stages behind it keep filling; s_axis_tready drops
// only once all three stages are full. Nothing is lost or repeated across a
// stall. aresetn (synchronous, active low) empties all stages; there is no
// other state, so no warm-up follows reset.
`default_nettype none

module ipv4_nat_checksum_rewrite (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // old_src, old_dst, new_src, new_dst, ip_checksum, header_words,
    // protocol, fragment_units, packet_length, l4_checksum, zero pad
    input  wire logic [ipv4nat_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // op
    input  wire logic [0:0]                            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // ip_checksum_out, l4_checksum_out, l4_offset, src_out, dst_out
    output logic [ipv4nat_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    // l4_write
    output logic [0:0]                                 m_axis_tuser
);
    import ipv4nat_pkg::*;

    in_item_t  in_item;
    s1_item_t  s1_item;
    s2_item_t  s2_item;
    out_item_t out_item;
    logic      s1_valid;
    logic      s1_ready;
    logic      s2_valid;
    logic      s2_ready;
    logic      l4_write;

    // Unpack the input word
    assign in_item = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);

    ipv4nat_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser[0]),
        .in_item   (in_item),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_item  (s1_item)
    );

    ipv4nat_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_item   (s1_item),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_item  (s2_item)
    );

    ipv4nat_final u_final (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s2_valid),
        .in_ready     (s2_ready),
        .in_item      (s2_item),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_item     (out_item),
        .out_l4_write (l4_write)
    );

    assign m_axis_tdata = out_item;
    assign m_axis_tuser = l4_write;

endmodule

`default_nettype wire

// ===== hw/rtl/ipv4nat_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module ipv4nat_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic [ipv4nat_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    input wire logic [0:0]                         s_axis_tuser,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [ipv4nat_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic [0:0]                         m_axis_tuser
);

    // A stalled input word holds until taken
    `ASSERT_NEXT(a_in_hold, aclk, aresetn, s_axis_tvalid && !s_axis_tready, s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser), "input word changed under stall")

    // A stalled output word holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed under stall")

    // With the output register empty, every stage behind it has room
    `ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")

    // No L4 write means zero L4 checksum and offset
    `ASSERT_IMPLIES(a_no_write_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata[47:16] == 32'd0, "L4 fields set without l4_write")

    // A written L4 offset fits in seven bits, below 128
    `ASSERT_IMPLIES(a_offset_range, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[47:39] == 9'd0, "L4 offset out of range")

endmodule

bind ipv4_nat_checksum_rewrite ipv4nat_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
